// ===== hw/rtl/trdt_pkg.sv =====
package trdt_pkg;

    // Action codes carried by the input word.
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    localparam logic [9:0] SCREEN_RESET = 10'd512;

    // One classified word as it waits between front and back.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [10:0] ax;
        logic signed [10:0] ay;
        logic signed [15:0] az;
        logic signed [10:0] bx;
        logic signed [10:0] by_coord;
        logic signed [15:0] bz;
        logic signed [10:0] cx;
        logic signed [10:0] cy;
        logic signed [15:0] cz;
        logic [8:0]         clear_x;
        logic [8:0]         clear_y;
    } cmd_t;

    // Control from the back part to the front part.
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

endpackage

// ===== hw/rtl/trdt_ram.sv =====
module trdt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/trdt_front.sv =====
module trdt_front #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [10:0] ax,
    input  logic signed [10:0] ay,
    input  logic signed [15:0] az,
    input  logic signed [10:0] bx,
    input  logic signed [10:0] by_coord,
    input  logic signed [15:0] bz,
    input  logic signed [10:0] cx,
    input  logic signed [10:0] cy,
    input  logic signed [15:0] cz,
    input  logic [8:0]         clear_x,
    input  logic [8:0]         clear_y,
    input  trdt_pkg::back_ctl_t ctl,
    output logic               head_valid,
    output trdt_pkg::cmd_t     head
);

    trdt_pkg::cmd_t q_mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           accept;
    logic           keep;
    logic           push;
    logic           pop;
    logic           clear_ok;

    assign in_stall = (cnt_reg == 2'd2) || ctl.clearing;
    assign accept   = in_valid && !in_stall;

    // Unused codes and clears outside the store are dropped here.
    assign clear_ok = (13'(clear_x) < 13'(MAX_WIDTH)) && (13'(clear_y) < 13'(MAX_HEIGHT));
    always_comb
    begin
        unique case (action)
            trdt_pkg::ACT_LOAD:  keep = 1'b1;
            trdt_pkg::ACT_STEP:  keep = 1'b1;
            trdt_pkg::ACT_CLEAR: keep = clear_ok;
            default:             keep = 1'b0;
        endcase
    end

    assign push       = accept && keep;
    assign pop        = ctl.pop && (cnt_reg != 2'd0);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{kind: action, ax: ax, ay: ay, az: az, bx: bx,
                                      by_coord: by_coord, bz: bz, cx: cx, cy: cy, cz: cz,
                                      clear_x: clear_x, clear_y: clear_y};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hw/rtl/trdt_back.sv =====
module trdt_back #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int DEPTH_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [9:0]          screen_width,
    input  logic [9:0]          screen_height,
    input  logic                head_valid,
    input  trdt_pkg::cmd_t      head,
    output trdt_pkg::back_ctl_t ctl,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [8:0]          frag_x,
    output logic [8:0]          frag_y,
    output logic signed [15:0]  frag_depth,
    output logic [15:0]         weight_a,
    output logic [15:0]         weight_b,
    output logic [15:0]         weight_c,
    output logic                frag_valid,
    output logic                last
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [33:0] ZNEAR = 34'((longint'(1) << (DEPTH_BITS - 1)) - 1);
    localparam logic signed [33:0] ZFAR  = -ZNEAR - 34'sd1;
    localparam logic [DEPTH_BITS-1:0] FAR_WORD = {1'b1, {(DEPTH_BITS - 1){1'b0}}};

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_LA   = 5'd2;
    localparam logic [4:0] S_LB   = 5'd3;
    localparam logic [4:0] S_LC   = 5'd4;
    localparam logic [4:0] S_DIV  = 5'd5;
    localparam logic [4:0] S_REJ  = 5'd6;
    localparam logic [4:0] S_PM1  = 5'd7;
    localparam logic [4:0] S_PM2  = 5'd8;
    localparam logic [4:0] S_PM3  = 5'd9;
    localparam logic [4:0] S_PM4  = 5'd10;
    localparam logic [4:0] S_PE   = 5'd11;
    localparam logic [4:0] S_PW1  = 5'd12;
    localparam logic [4:0] S_PW2  = 5'd13;
    localparam logic [4:0] S_PW3  = 5'd14;
    localparam logic [4:0] S_PZ1  = 5'd15;
    localparam logic [4:0] S_PZ2  = 5'd16;
    localparam logic [4:0] S_PZ3  = 5'd17;
    localparam logic [4:0] S_PZ4  = 5'd18;
    localparam logic [4:0] S_PRES = 5'd19;

    function automatic logic signed [10:0] min3(input logic signed [10:0] a,
                                                input logic signed [10:0] b,
                                                input logic signed [10:0] c);
        logic signed [10:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [10:0] max3(input logic signed [10:0] a,
                                                input logic signed [10:0] b,
                                                input logic signed [10:0] c);
        logic signed [10:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Control state.
    logic [4:0]    state_reg;
    logic [4:0]    state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [4:0]    div_cnt_reg;
    logic          tri_active_reg;
    logic          out_valid_reg;

    // Datapath state.
    logic signed [10:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [15:0] az_reg, bz_reg, cz_reg;
    logic signed [11:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic signed [11:0] cur_x_reg, cur_y_reg;
    logic signed [25:0] area_reg;
    logic               area_neg_reg;
    logic [24:0]        mag_reg;
    logic [24:0]        rem_reg;
    logic [31:0]        q_reg;
    logic [31:0]        recip_reg;
    logic signed [61:0] prod_reg;
    logic signed [34:0] acc_reg;
    logic signed [26:0] ux_reg;
    logic signed [27:0] eb_reg, ec_reg;
    logic [15:0]        wb_reg, wc_reg, wa_reg;
    logic signed [17:0] z_reg;
    logic               cov_reg;
    logic [8:0]         o_x_reg, o_y_reg;
    logic [15:0]        o_z_reg, o_wa_reg, o_wb_reg, o_wc_reg;
    logic               o_fv_reg, o_last_reg;

    // Combinational datapath.
    logic signed [12:0] dbx, dby, dcx, dcy, dapx, dapy;
    logic signed [27:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [10:0] xlo_raw, xhi_raw, ylo_raw, yhi_raw;
    logic signed [13:0] wlim, hlim;
    logic signed [11:0] xlo_c, xhi_c, ylo_c, yhi_c;
    logic signed [25:0] area_c;
    logic signed [25:0] area_abs;
    logic signed [26:0] uy_c;
    logic signed [27:0] ea_raw;
    logic signed [27:0] ea_c, eb_c, ec_c;
    logic [25:0]        rem_sh;
    logic               rem_ge;
    logic [16:0]        wa_c;
    logic signed [34:0] num_c, num_abs;
    logic [19:0]        zm_c;
    logic signed [33:0] zw, zs;
    logic [DEPTH_BITS-1:0] rd_data;
    logic               pass;
    logic               out_free;
    logic               last_c;
    logic               emit_pix;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [DEPTH_BITS-1:0] wr_data;
    logic [AW-1:0]      cur_addr;
    logic [AW-1:0]      clr_addr;
    logic               box_empty;

    assign dbx  = 13'(bx_reg) - 13'(ax_reg);
    assign dby  = 13'(by_reg) - 13'(ay_reg);
    assign dcx  = 13'(cx_reg) - 13'(ax_reg);
    assign dcy  = 13'(cy_reg) - 13'(ay_reg);
    assign dapx = 13'(ax_reg) - 13'(cur_x_reg);
    assign dapy = 13'(ay_reg) - 13'(cur_y_reg);

    // One shared multiplier; every product is registered before use.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_LA:  begin mul_a = 28'(dcx); mul_b = 34'(dby); end
            S_LB:  begin mul_a = 28'(dbx); mul_b = 34'(dcy); end
            S_PM1: begin mul_a = 28'(dbx); mul_b = 34'(dapy); end
            S_PM2: begin mul_a = 28'(dapx); mul_b = 34'(dby); end
            S_PM3: begin mul_a = 28'(dapx); mul_b = 34'(dcy); end
            S_PM4: begin mul_a = 28'(dcx); mul_b = 34'(dapy); end
            S_PW1: begin mul_a = eb_reg; mul_b = $signed({2'b00, recip_reg}); end
            S_PW2: begin mul_a = ec_reg; mul_b = $signed({2'b00, recip_reg}); end
            S_PZ1: begin mul_a = 28'(az_reg); mul_b = $signed({17'd0, wa_c}); end
            S_PZ2: begin mul_a = 28'(bz_reg); mul_b = $signed({18'd0, wb_reg}); end
            S_PZ3: begin mul_a = 28'(cz_reg); mul_b = $signed({18'd0, wc_reg}); end
            default: ;
        endcase
    end

    // Bounding box of the incoming triangle, clipped to the screen.
    assign xlo_raw = min3(head.ax, head.bx, head.cx);
    assign xhi_raw = max3(head.ax, head.bx, head.cx);
    assign ylo_raw = min3(head.ay, head.by_coord, head.cy);
    assign yhi_raw = max3(head.ay, head.by_coord, head.cy);
    assign wlim = ({4'd0, screen_width} < 14'(MAX_WIDTH)) ?
                  $signed({4'd0, screen_width}) : $signed(14'(MAX_WIDTH));
    assign hlim = ({4'd0, screen_height} < 14'(MAX_HEIGHT)) ?
                  $signed({4'd0, screen_height}) : $signed(14'(MAX_HEIGHT));
    assign xlo_c = (xlo_raw < 11'sd0) ? 12'sd0 : 12'(xlo_raw);
    assign ylo_c = (ylo_raw < 11'sd0) ? 12'sd0 : 12'(ylo_raw);
    assign xhi_c = (14'(xhi_raw) > wlim - 14'sd1) ? 12'(wlim - 14'sd1) : 12'(xhi_raw);
    assign yhi_c = (14'(yhi_raw) > hlim - 14'sd1) ? 12'(hlim - 14'sd1) : 12'(yhi_raw);

    assign area_c    = 26'(acc_reg - 35'(prod_reg));
    assign area_abs  = area_c[25] ? -area_c : area_c;
    assign box_empty = (xlo_reg > xhi_reg) || (ylo_reg > yhi_reg);

    // Restoring divider for floor(2^31 / |area|), one quotient bit a cycle.
    assign rem_sh = {rem_reg, q_reg[31]};
    assign rem_ge = rem_sh >= {1'b0, mag_reg};

    // Edge functions, with the sign of the area folded in.
    assign uy_c   = 27'(acc_reg - 35'(prod_reg));
    assign ea_raw = 28'(area_reg) - 28'(ux_reg) - 28'(uy_c);
    assign ea_c   = area_neg_reg ? -ea_raw : ea_raw;
    assign eb_c   = area_neg_reg ? -28'(uy_c) : 28'(uy_c);
    assign ec_c   = area_neg_reg ? -28'(ux_reg) : 28'(ux_reg);

    assign wa_c = 17'd32768 - 17'(wb_reg) - 17'(wc_reg);

    // Interpolated depth, truncated toward zero.
    assign num_c   = acc_reg + 35'(prod_reg);
    assign num_abs = num_c[34] ? -num_c : num_c;
    assign zm_c    = num_abs[34:15];

    assign zw = 34'(z_reg);
    always_comb
    begin
        priority if (zw > ZNEAR)
        begin
            zs = ZNEAR;
        end
        else if (zw < ZFAR)
        begin
            zs = ZFAR;
        end
        else
        begin
            zs = zw;
        end
    end
    assign pass = cov_reg && ($signed(DEPTH_BITS'(zs)) >= $signed(rd_data));

    assign out_free = !out_valid_reg || !out_stall;
    assign last_c   = (cur_x_reg == xhi_reg) && (cur_y_reg == yhi_reg);
    assign emit_pix = (state_reg == S_PRES) && out_free;

    assign cur_addr = AW'(cur_x_reg[10:0]) * AW'(MAX_HEIGHT) + AW'(cur_y_reg[10:0]);
    assign clr_addr = AW'(head.clear_x) * AW'(MAX_HEIGHT) + AW'(head.clear_y);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = FAR_WORD;
        priority if (state_reg == S_CLR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
        end
        else if (state_reg == S_IDLE && head_valid && head.kind == trdt_pkg::ACT_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr;
        end
        else if (emit_pix && pass)
        begin
            wr_en   = 1'b1;
            wr_data = DEPTH_BITS'(zs);
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    trdt_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (DEPTH)
    ) u_depth (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (state_reg == S_PE),
        .rd_addr (cur_addr),
        .rd_data (rd_data)
    );

    assign ctl.pop      = (state_reg == S_IDLE);
    assign ctl.clearing = (state_reg == S_CLR);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_cnt_reg == AW'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.kind == trdt_pkg::ACT_LOAD)
                    begin
                        state_next = S_LA;
                    end
                    else if (head.kind == trdt_pkg::ACT_STEP && tri_active_reg)
                    begin
                        state_next = S_PM1;
                    end
                end
            end
            S_LA:   state_next = S_LB;
            S_LB:   state_next = S_LC;
            S_LC:   state_next = (area_c == 26'sd0 || box_empty) ? S_REJ : S_DIV;
            S_DIV:  if (div_cnt_reg == 5'd31) state_next = S_IDLE;
            S_REJ:  if (out_free) state_next = S_IDLE;
            S_PM1:  state_next = S_PM2;
            S_PM2:  state_next = S_PM3;
            S_PM3:  state_next = S_PM4;
            S_PM4:  state_next = S_PE;
            S_PE:   state_next = (!ea_c[27] && !eb_c[27] && !ec_c[27]) ? S_PW1 : S_PRES;
            S_PW1:  state_next = S_PW2;
            S_PW2:  state_next = S_PW3;
            S_PW3:  state_next = S_PZ1;
            S_PZ1:  state_next = S_PZ2;
            S_PZ2:  state_next = S_PZ3;
            S_PZ3:  state_next = S_PZ4;
            S_PZ4:  state_next = S_PRES;
            S_PRES: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_cnt_reg    <= '0;
            div_cnt_reg    <= '0;
            tri_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            div_cnt_reg <= (state_reg == S_DIV) ? div_cnt_reg + 5'd1 : 5'd0;
            if (state_reg == S_IDLE && head_valid && head.kind == trdt_pkg::ACT_LOAD)
            begin
                tri_active_reg <= 1'b0;
            end
            else if (state_reg == S_DIV && div_cnt_reg == 5'd31)
            begin
                tri_active_reg <= 1'b1;
            end
            else if (emit_pix && last_c)
            begin
                tri_active_reg <= 1'b0;
            end
            if ((state_reg == S_REJ || state_reg == S_PRES) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid && head.kind == trdt_pkg::ACT_LOAD)
                begin
                    ax_reg  <= head.ax;
                    ay_reg  <= head.ay;
                    az_reg  <= head.az;
                    bx_reg  <= head.bx;
                    by_reg  <= head.by_coord;
                    bz_reg  <= head.bz;
                    cx_reg  <= head.cx;
                    cy_reg  <= head.cy;
                    cz_reg  <= head.cz;
                    xlo_reg <= xlo_c;
                    xhi_reg <= xhi_c;
                    ylo_reg <= ylo_c;
                    yhi_reg <= yhi_c;
                end
            end
            S_LB, S_PM2, S_PM4:
            begin
                acc_reg <= 35'(prod_reg);
            end
            S_LC:
            begin
                area_reg     <= area_c;
                area_neg_reg <= area_c[25];
                mag_reg      <= area_abs[24:0];
                rem_reg      <= '0;
                q_reg        <= 32'h8000_0000;
            end
            S_DIV:
            begin
                rem_reg <= rem_ge ? 25'(rem_sh - {1'b0, mag_reg}) : rem_sh[24:0];
                q_reg   <= {q_reg[30:0], rem_ge};
                if (div_cnt_reg == 5'd31)
                begin
                    recip_reg <= {q_reg[30:0], rem_ge};
                    cur_x_reg <= xlo_reg;
                    cur_y_reg <= ylo_reg;
                end
            end
            S_PM3:
            begin
                ux_reg  <= 27'(acc_reg - 35'(prod_reg));
                acc_reg <= acc_reg;
            end
            S_PE:
            begin
                eb_reg  <= eb_c;
                ec_reg  <= ec_c;
                cov_reg <= !ea_c[27] && !eb_c[27] && !ec_c[27];
            end
            S_PW2:
            begin
                wb_reg <= prod_reg[31:16];
            end
            S_PW3:
            begin
                wc_reg <= prod_reg[31:16];
            end
            S_PZ1:
            begin
                wa_reg <= wa_c[15:0];
            end
            S_PZ2:
            begin
                acc_reg <= 35'(prod_reg);
            end
            S_PZ3:
            begin
                acc_reg <= acc_reg + 35'(prod_reg);
            end
            S_PZ4:
            begin
                z_reg <= num_c[34] ? -$signed({1'b0, 17'(zm_c)}) : $signed({1'b0, 17'(zm_c)});
            end
            S_PRES:
            begin
                if (out_free)
                begin
                    if (cur_y_reg < yhi_reg)
                    begin
                        cur_y_reg <= cur_y_reg + 12'sd1;
                    end
                    else
                    begin
                        cur_y_reg <= ylo_reg;
                        cur_x_reg <= cur_x_reg + 12'sd1;
                    end
                end
            end
            default: ;
        endcase

        if (state_reg == S_REJ && out_free)
        begin
            o_x_reg    <= '0;
            o_y_reg    <= '0;
            o_z_reg    <= '0;
            o_wa_reg   <= '0;
            o_wb_reg   <= '0;
            o_wc_reg   <= '0;
            o_fv_reg   <= 1'b0;
            o_last_reg <= 1'b1;
        end
        else if (emit_pix)
        begin
            o_x_reg    <= cur_x_reg[8:0];
            o_y_reg    <= cur_y_reg[8:0];
            o_z_reg    <= pass ? z_reg[15:0] : 16'd0;
            o_wa_reg   <= pass ? wa_reg : 16'd0;
            o_wb_reg   <= pass ? wb_reg : 16'd0;
            o_wc_reg   <= pass ? wc_reg : 16'd0;
            o_fv_reg   <= pass;
            o_last_reg <= last_c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frag_x     = o_x_reg;
    assign frag_y     = o_y_reg;
    assign frag_depth = $signed(o_z_reg);
    assign weight_a   = o_wa_reg;
    assign weight_b   = o_wb_reg;
    assign weight_c   = o_wc_reg;
    assign frag_valid = o_fv_reg;
    assign last       = o_last_reg;

endmodule

// ===== hw/rtl/triangle_raster_depth_test_unit.sv =====
// Triangle rasterizer with an internal depth buffer.
// Input channel (in_valid / in_stall) carries one word per action: load a
// triangle, step to the next pixel of its bounding box (x outer, y inner), or
// clear one depth entry. Output channel (out_valid / out_stall) carries one
// word per visited pixel, plus one word with last set for a rejected load.
// Screen width and height are written through cfg_wr_en / cfg_index / cfg_data
// while the block is idle.
// Pacing: a load is paced by the one-bit-per-cycle divider that forms the
// area reciprocal. A step is paced by the single shared multiplier, and a
// covered pixel takes more multiplier steps than an uncovered one. A clear
// is written from the idle state. A two-word queue sits between the input and
// the sequencer, and a result register parts the sequencer from the output.
// After reset the depth buffer is swept to the farthest value, one entry a
// cycle over all MAX_WIDTH * MAX_HEIGHT entries, and in_stall stays high meanwhile.
// While the receiver stalls, the output word holds and the sequencer waits
// only when it has the next word ready; the queue keeps taking input until full.
module triangle_raster_depth_test_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int DEPTH_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [10:0] ax,
    input  logic signed [10:0] ay,
    input  logic signed [15:0] az,
    input  logic signed [10:0] bx,
    input  logic signed [10:0] by_coord,
    input  logic signed [15:0] bz,
    input  logic signed [10:0] cx,
    input  logic signed [10:0] cy,
    input  logic signed [15:0] cz,
    input  logic [8:0]         clear_x,
    input  logic [8:0]         clear_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [8:0]         frag_x,
    output logic [8:0]         frag_y,
    output logic signed [15:0] frag_depth,
    output logic [15:0]        weight_a,
    output logic [15:0]        weight_b,
    output logic [15:0]        weight_c,
    output logic               frag_valid,
    output logic               last
);

    logic [9:0]          screen_width_reg;
    logic [9:0]          screen_height_reg;
    logic                head_valid;
    trdt_pkg::cmd_t      head;
    trdt_pkg::back_ctl_t ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= trdt_pkg::SCREEN_RESET;
            screen_height_reg <= trdt_pkg::SCREEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == trdt_pkg::REG_WIDTH)
            begin
                screen_width_reg <= cfg_data;
            end
            else if (cfg_index == trdt_pkg::REG_HEIGHT)
            begin
                screen_height_reg <= cfg_data;
            end
        end
    end

    trdt_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .ax         (ax),
        .ay         (ay),
        .az         (az),
        .bx         (bx),
        .by_coord   (by_coord),
        .bz         (bz),
        .cx         (cx),
        .cy         (cy),
        .cz         (cz),
        .clear_x    (clear_x),
        .clear_y    (clear_y),
        .ctl        (ctl),
        .head_valid (head_valid),
        .head       (head)
    );

    trdt_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .head_valid    (head_valid),
        .head          (head),
        .ctl           (ctl),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frag_x        (frag_x),
        .frag_y        (frag_y),
        .frag_depth    (frag_depth),
        .weight_a      (weight_a),
        .weight_b      (weight_b),
        .weight_c      (weight_c),
        .frag_valid    (frag_valid),
        .last          (last)
    );

endmodule

// ===== hw/rtl/trdt_checker.sv =====
module trdt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [8:0]         frag_x,
    input logic [8:0]         frag_y,
    input logic signed [15:0] frag_depth,
    input logic [15:0]        weight_a,
    input logic [15:0]        weight_b,
    input logic [15:0]        weight_c,
    input logic               frag_valid
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_hold_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(frag_x) && $stable(frag_y))
        else $error("stalled pixel position changed");

    // A pixel that is not shaded carries no weights and no depth.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frag_valid |-> weight_a == 16'd0 && weight_b == 16'd0
                                     && weight_c == 16'd0 && frag_depth == 16'sd0)
        else $error("unshaded word has nonzero fields");

    // Shaded weights always sum to one in Q1.15.
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frag_valid |->
            (18'(weight_a) + 18'(weight_b) + 18'(weight_c)) == 18'd32768)
        else $error("weights do not sum to one");

endmodule

bind triangle_raster_depth_test_unit trdt_checker u_trdt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frag_x     (frag_x),
    .frag_y     (frag_y),
    .frag_depth (frag_depth),
    .weight_a   (weight_a),
    .weight_b   (weight_b),
    .weight_c   (weight_c),
    .frag_valid (frag_valid)
);

// ===== verif/triangle_raster_depth_test_unit_tb.sv =====
`timescale 1ns / 100ps

module triangle_raster_depth_test_unit_tb;

    localparam int GRID_W = 512;
    localparam int GRID_H = 512;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 1600;
    localparam logic [1:0] REG_SPARE = 2'd2;

    typedef struct packed {
        logic [8:0]         x;
        logic [8:0]         y;
        logic signed [15:0] depth;
        logic [15:0]        wa;
        logic [15:0]        wb;
        logic [15:0]        wc;
        logic               valid;
        logic               last;
    } frag_t;

    typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t      kind;
        trdt_pkg::cmd_t word;
        int             rep;
        bit             typed;
        frag_t          want;
        logic [1:0]     reg_index;
        logic [9:0]     reg_value;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [1:0]         cfg_index;
    logic [9:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic signed [10:0] ax, ay, bx, by_coord, cx, cy;
    logic signed [15:0] az, bz, cz;
    logic [8:0]         clear_x, clear_y;
    logic               out_valid;
    logic               out_stall;
    logic [8:0]         frag_x, frag_y;
    logic signed [15:0] frag_depth;
    logic [15:0]        weight_a, weight_b, weight_c;
    logic               frag_valid;
    logic               last;

    triangle_raster_depth_test_unit dut (.*);

    // Predictor state.
    longint  vx[3], vy[3], vz[3];
    longint  box_xlo, box_xhi, box_ylo, box_yhi, cur_x, cur_y, recip;
    bit      area_neg, tri_live;
    int      scr_w, scr_h;
    shortint zbuf [0:GRID_W*GRID_H-1];

    frag_t pending_frags[$];
    row_t  plan[$];
    int    errors, n_frags, n_shaded, n_rejected, n_words;
    bit    quiet;
    int    stall_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int gap_draw();
        return quiet ? 0 : int'($urandom_range(0, 19));
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic longint twice_area();
        return (vx[2] - vx[0]) * (vy[1] - vy[0]) - (vx[1] - vx[0]) * (vy[2] - vy[0]);
    endfunction

    // Applies one word to the predicted block state; returns the fragment it causes.
    task automatic rasterize_word(input trdt_pkg::cmd_t c, output bit has, output frag_t r);
        longint area, w, h, xlo, xhi, ylo, yhi, mag, px, py, ux, uy, ea, eb, ec;
        longint wa, wb, wc, num, z, zs;
        int idx;
        has = 1'b0;
        r = '0;
        case (c.kind)
            trdt_pkg::ACT_LOAD:
            begin
                n_words++;
                vx[0] = $signed(c.ax); vy[0] = $signed(c.ay); vz[0] = $signed(c.az);
                vx[1] = $signed(c.bx); vy[1] = $signed(c.by_coord); vz[1] = $signed(c.bz);
                vx[2] = $signed(c.cx); vy[2] = $signed(c.cy); vz[2] = $signed(c.cz);
                w = (scr_w < GRID_W) ? scr_w : GRID_W;
                h = (scr_h < GRID_H) ? scr_h : GRID_H;
                xlo = vx[0]; xhi = vx[0]; ylo = vy[0]; yhi = vy[0];
                for (int i = 1; i < 3; i++)
                begin
                    if (vx[i] < xlo) xlo = vx[i];
                    if (vx[i] > xhi) xhi = vx[i];
                    if (vy[i] < ylo) ylo = vy[i];
                    if (vy[i] > yhi) yhi = vy[i];
                end
                if (xlo < 0) xlo = 0;
                if (ylo < 0) ylo = 0;
                if (xhi > w - 1) xhi = w - 1;
                if (yhi > h - 1) yhi = h - 1;
                area = twice_area();
                tri_live = 1'b0;
                if (area == 0 || xlo > xhi || ylo > yhi)
                begin
                    has = 1'b1;
                    r.last = 1'b1;
                    n_rejected++;
                end
                else
                begin
                    area_neg = area < 0;
                    mag = area_neg ? -area : area;
                    recip = (64'sd1 << 31) / mag;
                    box_xlo = xlo; box_xhi = xhi; box_ylo = ylo; box_yhi = yhi;
                    cur_x = xlo;
                    cur_y = ylo;
                    tri_live = 1'b1;
                end
            end
            trdt_pkg::ACT_CLEAR:
            begin
                n_words++;
                zbuf[int'(c.clear_x) * GRID_H + int'(c.clear_y)] = -16'sd32768;
            end
            trdt_pkg::ACT_STEP:
            begin
                if (tri_live)
                begin
                    n_words++;
                    has = 1'b1;
                    px = cur_x;
                    py = cur_y;
                    ux = (vx[1] - vx[0]) * (vy[0] - py) - (vx[0] - px) * (vy[1] - vy[0]);
                    uy = (vx[0] - px) * (vy[2] - vy[0]) - (vx[2] - vx[0]) * (vy[0] - py);
                    area = twice_area();
                    ea = area - ux - uy;
                    eb = uy;
                    ec = ux;
                    if (area_neg)
                    begin
                        ea = -ea; eb = -eb; ec = -ec;
                    end
                    if (ea >= 0 && eb >= 0 && ec >= 0)
                    begin
                        wb = (eb * recip) >>> 16;
                        wc = (ec * recip) >>> 16;
                        wa = 32768 - wb - wc;
                        num = vz[0] * wa + vz[1] * wb + vz[2] * wc;
                        z = (num >= 0) ? (num >>> 15) : -((-num) >>> 15);
                        zs = z;
                        if (zs > 32767) zs = 32767;
                        if (zs < -32768) zs = -32768;
                        idx = int'(px) * GRID_H + int'(py);
                        if (zs >= zbuf[idx])
                        begin
                            zbuf[idx] = shortint'(zs);
                            r.valid = 1'b1;
                            r.depth = z[15:0];
                            r.wa = wa[15:0];
                            r.wb = wb[15:0];
                            r.wc = wc[15:0];
                        end
                    end
                    r.x = px[8:0];
                    r.y = py[8:0];
                    r.last = (px == box_xhi && py == box_yhi);
                    if (py < box_yhi)
                        cur_y = py + 1;
                    else
                    begin
                        cur_y = box_ylo;
                        cur_x = px + 1;
                    end
                    if (r.last)
                        tri_live = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Presents one word, waits for it to be taken, then records what it should cause.
    task automatic send_word(input trdt_pkg::cmd_t c, input bit typed, input frag_t want);
        int gap;
        bit has;
        frag_t r;
        gap = gap_draw();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= c.kind;
        ax <= c.ax; ay <= c.ay; az <= c.az;
        bx <= c.bx; by_coord <= c.by_coord; bz <= c.bz;
        cx <= c.cx; cy <= c.cy; cz <= c.cz;
        clear_x <= c.clear_x;
        clear_y <= c.clear_y;
        do @(posedge clk); while (in_stall);
        rasterize_word(c, has, r);
        if (typed)
            pending_frags.push_back(want);
        else if (has)
            pending_frags.push_back(r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_frags.size() != 0)
            @(posedge clk);
        // A load or a step may still be in flight without any fragment owed.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [9:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (index == trdt_pkg::REG_WIDTH)
            scr_w = int'(value);
        else if (index == trdt_pkg::REG_HEIGHT)
            scr_h = int'(value);
    endtask

    function automatic trdt_pkg::cmd_t random_word(input logic [1:0] kind);
        trdt_pkg::cmd_t c;
        c = trdt_pkg::cmd_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        c.kind = kind;
        return c;
    endfunction

    function automatic trdt_pkg::cmd_t tri_word(input int x0, y0, z0, x1, y1, z1,
                                                x2, y2, z2);
        trdt_pkg::cmd_t c;
        c = random_word(trdt_pkg::ACT_LOAD);
        c.ax = 11'(x0); c.ay = 11'(y0); c.az = 16'(z0);
        c.bx = 11'(x1); c.by_coord = 11'(y1); c.bz = 16'(z1);
        c.cx = 11'(x2); c.cy = 11'(y2); c.cz = 16'(z2);
        return c;
    endfunction

    function automatic frag_t frag(input int x, y, d, wa, wb, wc, v, l);
        frag_t f;
        f.x = 9'(x); f.y = 9'(y); f.depth = 16'(d);
        f.wa = 16'(wa); f.wb = 16'(wb); f.wc = 16'(wc);
        f.valid = 1'(v); f.last = 1'(l);
        return f;
    endfunction

    task automatic add_word(input trdt_pkg::cmd_t c, input int rep);
        row_t r;
        r = '{kind: ROW_WORD, word: c, rep: rep, typed: 1'b0, want: '0,
              reg_index: '0, reg_value: '0};
        plan.push_back(r);
    endtask

    task automatic add_typed(input trdt_pkg::cmd_t c, input frag_t want);
        row_t r;
        r = '{kind: ROW_WORD, word: c, rep: 1, typed: 1'b1, want: want,
              reg_index: '0, reg_value: '0};
        plan.push_back(r);
    endtask

    task automatic add_reg(input logic [1:0] index, input logic [9:0] value);
        row_t r;
        r = '{kind: ROW_REG, word: '0, rep: 0, typed: 1'b0, want: '0,
              reg_index: index, reg_value: value};
        plan.push_back(r);
    endtask

    // Loads a triangle and walks its box, either to the end or cut short.
    task automatic random_triangle();
        int w_eff, h_eff, bxp, byp, cap, k;
        trdt_pkg::cmd_t c;
        w_eff = (scr_w < 1) ? 1 : ((scr_w > GRID_W) ? GRID_W : scr_w);
        h_eff = (scr_h < 1) ? 1 : ((scr_h > GRID_H) ? GRID_H : scr_h);
        bxp = $urandom_range(0, w_eff - 1);
        byp = $urandom_range(0, h_eff - 1);
        c = random_word(trdt_pkg::ACT_LOAD);
        if ($urandom_range(0, 9) != 0)
        begin
            c.ax = 11'(bxp + int'($urandom_range(0, 12)) - 6);
            c.ay = 11'(byp + int'($urandom_range(0, 12)) - 6);
            c.bx = 11'(bxp + int'($urandom_range(0, 12)) - 6);
            c.by_coord = 11'(byp + int'($urandom_range(0, 12)) - 6);
            c.cx = 11'(bxp + int'($urandom_range(0, 12)) - 6);
            c.cy = 11'(byp + int'($urandom_range(0, 12)) - 6);
            if ($urandom_range(0, 3) == 0)
            begin
                // Nearby depths so that overlapping triangles fight the depth test.
                c.az = 16'(int'($urandom_range(0, 200)) - 100);
                c.bz = 16'(int'($urandom_range(0, 200)) - 100);
                c.cz = 16'(int'($urandom_range(0, 200)) - 100);
            end
        end
        send_word(c, 1'b0, '0);
        cap = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 40)) : 400;
        k = 0;
        while (tri_live && k < cap)
        begin
            send_word(random_word(trdt_pkg::ACT_STEP), 1'b0, '0);
            k++;
        end
    endtask

    task automatic random_phase(input int quota);
        int start, pick, x0, y0, dx, dy;
        start = n_words;
        while (n_words - start < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                random_triangle();
            else if (pick < 80)
                send_word(random_word(trdt_pkg::ACT_CLEAR), 1'b0, '0);
            else if (pick < 85)
                send_word(random_word(trdt_pkg::ACT_NONE), 1'b0, '0);
            else if (pick < 90)
                send_word(random_word(trdt_pkg::ACT_STEP), 1'b0, '0);
            else
            begin
                // Collinear vertices: zero area.
                x0 = $urandom_range(0, 40);
                y0 = $urandom_range(0, 40);
                dx = int'($urandom_range(0, 8)) - 4;
                dy = int'($urandom_range(0, 8)) - 4;
                send_word(tri_word(x0, y0, int'($urandom()), x0 + dx, y0 + dy,
                                   int'($urandom()), x0 + 2 * dx, y0 + 2 * dy,
                                   int'($urandom())), 1'b0, '0);
            end
        end
    endtask

    // Output side: check each taken word and stall at random.
    always @(posedge clk)
    begin
        frag_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = frag(frag_x, frag_y, frag_depth, weight_a, weight_b, weight_c,
                       frag_valid, last);
            n_frags++;
            if (frag_valid)
                n_shaded++;
            if (pending_frags.size() == 0)
                flag_mismatch("unexpected word, frag_x", got.x, -1);
            else
            begin
                want = pending_frags.pop_front();
                if (got.x != want.x) flag_mismatch("frag_x", got.x, want.x);
                if (got.y != want.y) flag_mismatch("frag_y", got.y, want.y);
                if (got.depth != want.depth) flag_mismatch("frag_depth", got.depth, want.depth);
                if (got.wa != want.wa) flag_mismatch("weight_a", got.wa, want.wa);
                if (got.wb != want.wb) flag_mismatch("weight_b", got.wb, want.wb);
                if (got.wc != want.wc) flag_mismatch("weight_c", got.wc, want.wc);
                if (got.valid != want.valid) flag_mismatch("frag_valid", got.valid, want.valid);
                if (got.last != want.last) flag_mismatch("last", got.last, want.last);
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                out_stall <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            stall_left = gap_draw();
            if (stall_left > 0)
                out_stall <= 1'b1;
        end
    end

    initial
    begin
        int phase_w[4];
        int phase_h[4];
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= trdt_pkg::REG_WIDTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        out_stall <= 1'b0;
        action <= trdt_pkg::ACT_NONE;
        ax <= '0; ay <= '0; az <= '0;
        bx <= '0; by_coord <= '0; bz <= '0;
        cx <= '0; cy <= '0; cz <= '0;
        clear_x <= '0;
        clear_y <= '0;
        errors = 0;
        n_frags = 0; n_shaded = 0; n_rejected = 0; n_words = 0;
        quiet = 1'b0;
        stall_left = 0;
        foreach (vx[i])
        begin
            vx[i] = 0; vy[i] = 0; vz[i] = 0;
        end
        box_xlo = 0; box_xhi = 0; box_ylo = 0; box_yhi = 0;
        cur_x = 0; cur_y = 0; recip = 0;
        area_neg = 1'b0;
        tri_live = 1'b0;
        scr_w = int'(trdt_pkg::SCREEN_RESET);
        scr_h = int'(trdt_pkg::SCREEN_RESET);
        foreach (zbuf[i])
            zbuf[i] = -16'sd32768;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        add_word(random_word(trdt_pkg::ACT_STEP), 1);
        add_word(random_word(trdt_pkg::ACT_NONE), 1);
        add_typed(tri_word(5, 5, 1, 5, 5, 2, 5, 5, 3), frag(0, 0, 0, 0, 0, 0, 0, 1));
        add_typed(tri_word(-10, -10, 7, -5, -20, 8, -1, -3, 9), frag(0, 0, 0, 0, 0, 0, 0, 1));
        add_word(tri_word(0, 0, 100, 3, 0, 200, 0, 3, 300), 1);
        add_typed(random_word(trdt_pkg::ACT_STEP), frag(0, 0, 100, 32768, 0, 0, 1, 0));
        add_word(random_word(trdt_pkg::ACT_STEP), 15);
        add_word(tri_word(0, 0, -5, 3, 0, -5, 0, 3, -5), 1);
        add_word(random_word(trdt_pkg::ACT_STEP), 16);
        add_word(random_word(trdt_pkg::ACT_CLEAR), 1);
        plan[plan.size() - 1].word.clear_x = 0;
        plan[plan.size() - 1].word.clear_y = 0;
        add_word(random_word(trdt_pkg::ACT_CLEAR), 1);
        plan[plan.size() - 1].word.clear_x = 511;
        plan[plan.size() - 1].word.clear_y = 511;
        add_word(tri_word(0, 0, 0, 3, 0, 0, 0, 3, 0), 1);
        add_word(random_word(trdt_pkg::ACT_STEP), 16);
        add_reg(trdt_pkg::REG_WIDTH, 10'd4);
        add_reg(trdt_pkg::REG_HEIGHT, 10'd3);
        add_word(tri_word(-1024, -1024, -32768, 1023, -1024, 32767, 1023, 1023, 0), 1);
        add_word(random_word(trdt_pkg::ACT_STEP), 13);
        add_reg(trdt_pkg::REG_WIDTH, 10'd0);
        add_typed(tri_word(0, 0, 1, 3, 0, 2, 0, 3, 3), frag(0, 0, 0, 0, 0, 0, 0, 1));
        add_reg(REG_SPARE, 10'h3FF);
        add_reg(trdt_pkg::REG_WIDTH, 10'h3FF);
        add_reg(trdt_pkg::REG_HEIGHT, 10'd512);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_index, plan[i].reg_value);
            else
                for (int k = 0; k < plan[i].rep; k++)
                    send_word(plan[i].word, plan[i].typed, plan[i].want);
        end

        phase_w = '{512, 37, 1, 1023};
        phase_h = '{512, 23, 512, 1};
        for (int p = 0; p < 4; p++)
        begin
            write_reg(trdt_pkg::REG_WIDTH, 10'(phase_w[p]));
            write_reg(trdt_pkg::REG_HEIGHT, 10'(phase_h[p]));
            quiet = (p == 1);
            random_phase(RANDOM_ITEMS / 4);
        end
        quiet = 1'b0;
        wait_drained();

        $display("Covered %0d counted words over four screen settings and the extremes.",
                 n_words);
        $display("Checked %0d fragments, %0d shaded and %0d rejected loads.",
                 n_frags, n_shaded, n_rejected);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
